### sv/cvr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cvr_pkg
// Shared types, constants and the arctangent table of the CORDIC rotator.
// ============================================================================
package cvr_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC_BITS      = 7;
    localparam int MAX_ITERATIONS = 8;
    localparam int ITERATIONS     = 8;
    localparam int COORD_W        = 8;
    localparam int ANGLE_W        = 10;
    localparam int VEC_W          = 16;
    localparam int ACC_W          = 10;   // residual angle, signed
    localparam int QUAD_W         = 2;
    localparam int CFG_IDX_W      = 8;

    // pi/2 with 7 fraction bits
    localparam int HALF_PI_FX = 201;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_START_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = CFG_IDX_W'(1);

    // Quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_0 = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_1 = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 2'd3;

    // Payload carried between pipeline stages
    typedef struct packed {
        logic [QUAD_W-1:0]       quad;
        logic signed [ACC_W-1:0] ang;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
    } stage_t;

    // atan(2^-i) in radians, 7 fraction bits
    function automatic logic signed [ACC_W-1:0] atan_val(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = ACC_W'(10'sh064);
            1:       v = ACC_W'(10'sh03B);
            2:       v = ACC_W'(10'sh01F);
            3:       v = ACC_W'(10'sh010);
            4:       v = ACC_W'(10'sh008);
            5:       v = ACC_W'(10'sh004);
            6:       v = ACC_W'(10'sh002);
            7:       v = ACC_W'(10'sh001);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/cvr_reduce.sv
`timescale 1ns / 1ps
// ============================================================================
// cvr_reduce
// Entry stage: folds the angle into one quadrant and loads the start vector.
// ============================================================================
module cvr_reduce (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [cvr_pkg::ANGLE_W-1:0]           angle,
    input  logic signed [cvr_pkg::COORD_W-1:0]    start_x,
    input  logic signed [cvr_pkg::COORD_W-1:0]    start_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cvr_pkg::stage_t                       out_data
);

    localparam int PAD_W = cvr_pkg::VEC_W - cvr_pkg::COORD_W - cvr_pkg::FRAC_BITS;
    localparam logic [cvr_pkg::ANGLE_W-1:0] HP1 = cvr_pkg::ANGLE_W'(cvr_pkg::HALF_PI_FX);
    localparam logic [cvr_pkg::ANGLE_W-1:0] HP2 = cvr_pkg::ANGLE_W'(2 * cvr_pkg::HALF_PI_FX);
    localparam logic [cvr_pkg::ANGLE_W-1:0] HP3 = cvr_pkg::ANGLE_W'(3 * cvr_pkg::HALF_PI_FX);
    localparam logic [cvr_pkg::ANGLE_W-1:0] HP4 = cvr_pkg::ANGLE_W'(4 * cvr_pkg::HALF_PI_FX);
    localparam logic [cvr_pkg::ANGLE_W-1:0] HP5 = cvr_pkg::ANGLE_W'(5 * cvr_pkg::HALF_PI_FX);

    logic                            valid_reg;
    cvr_pkg::stage_t                 data_reg;
    cvr_pkg::stage_t                 data_next;
    logic [cvr_pkg::ANGLE_W-1:0]     rem;
    logic [cvr_pkg::QUAD_W-1:0]      quad;

    // Quotient by pi/2 (at most five) kept modulo 4, remainder below pi/2
    always_comb begin
        if (angle >= HP5) begin
            quad = cvr_pkg::QUAD_1;
            rem  = angle - HP5;
        end else if (angle >= HP4) begin
            quad = cvr_pkg::QUAD_0;
            rem  = angle - HP4;
        end else if (angle >= HP3) begin
            quad = cvr_pkg::QUAD_3;
            rem  = angle - HP3;
        end else if (angle >= HP2) begin
            quad = cvr_pkg::QUAD_2;
            rem  = angle - HP2;
        end else if (angle >= HP1) begin
            quad = cvr_pkg::QUAD_1;
            rem  = angle - HP1;
        end else begin
            quad = cvr_pkg::QUAD_0;
            rem  = angle;
        end
    end

    // Start vector scaled up by the fraction bits
    always_comb begin
        data_next.quad = quad;
        data_next.ang  = signed'(cvr_pkg::ACC_W'(rem));
        data_next.x    = {{PAD_W{start_x[cvr_pkg::COORD_W-1]}}, start_x,
                          {cvr_pkg::FRAC_BITS{1'b0}}};
        data_next.y    = {{PAD_W{start_y[cvr_pkg::COORD_W-1]}}, start_y,
                          {cvr_pkg::FRAC_BITS{1'b0}}};
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/cvr_micro_rot.sv
`timescale 1ns / 1ps
// ============================================================================
// cvr_micro_rot
// One CORDIC micro-rotation stage, shift and arctangent fixed by STAGE.
// ============================================================================
module cvr_micro_rot #(
    parameter int STAGE = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  cvr_pkg::stage_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output cvr_pkg::stage_t out_data
);

    localparam logic signed [cvr_pkg::ACC_W-1:0] ATAN = cvr_pkg::atan_val(STAGE);

    logic                              valid_reg;
    cvr_pkg::stage_t                   data_reg;
    cvr_pkg::stage_t                   data_next;
    logic signed [cvr_pkg::VEC_W-1:0]  dx;
    logic signed [cvr_pkg::VEC_W-1:0]  dy;

    // Rotate toward zero residual angle; x and y wrap at 16 bits
    always_comb begin
        dx             = in_data.x >>> STAGE;
        dy             = in_data.y >>> STAGE;
        data_next.quad = in_data.quad;
        if (!in_data.ang[cvr_pkg::ACC_W-1]) begin
            data_next.x   = in_data.x - dy;
            data_next.y   = in_data.y + dx;
            data_next.ang = in_data.ang - ATAN;
        end else begin
            data_next.x   = in_data.x + dy;
            data_next.y   = in_data.y - dx;
            data_next.ang = in_data.ang + ATAN;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/cvr_gain_quad.sv
`timescale 1ns / 1ps
// ============================================================================
// cvr_gain_quad
// Output stage: CORDIC gain correction (0x4D/128) and quadrant restore.
// ============================================================================
module cvr_gain_quad (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cvr_pkg::stage_t                       in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [cvr_pkg::COORD_W-1:0]    out_x,
    output logic signed [cvr_pkg::COORD_W-1:0]    out_y
);

    localparam int SUM_W = cvr_pkg::VEC_W + 1;

    logic                                  valid_reg;
    logic signed [cvr_pkg::COORD_W-1:0]    x_reg;
    logic signed [cvr_pkg::COORD_W-1:0]    y_reg;
    logic signed [cvr_pkg::COORD_W-1:0]    x_next;
    logic signed [cvr_pkg::COORD_W-1:0]    y_next;
    logic signed [SUM_W-1:0]               xe;
    logic signed [SUM_W-1:0]               ye;
    logic signed [SUM_W-1:0]               xs;
    logic signed [SUM_W-1:0]               ys;
    logic signed [cvr_pkg::COORD_W-1:0]    gx;
    logic signed [cvr_pkg::COORD_W-1:0]    gy;

    // Gain as 1/128 + 1/32 + 1/16 + 1/2, then drop the fraction bits
    always_comb begin
        xe = SUM_W'(in_data.x);
        ye = SUM_W'(in_data.y);
        xs = (xe >>> 7) + (xe >>> 5) + (xe >>> 4) + (xe >>> 1);
        ys = (ye >>> 7) + (ye >>> 5) + (ye >>> 4) + (ye >>> 1);
        gx = xs[cvr_pkg::FRAC_BITS +: cvr_pkg::COORD_W];
        gy = ys[cvr_pkg::FRAC_BITS +: cvr_pkg::COORD_W];
    end

    // Swap and negate back into the original quadrant (low 8 bits only)
    always_comb begin
        case (in_data.quad)
            cvr_pkg::QUAD_0: begin
                x_next = gx;
                y_next = gy;
            end
            cvr_pkg::QUAD_1: begin
                x_next = -gy;
                y_next = gx;
            end
            cvr_pkg::QUAD_2: begin
                x_next = -gx;
                y_next = -gy;
            end
            cvr_pkg::QUAD_3: begin
                x_next = gy;
                y_next = -gx;
            end
            default: begin
                x_next = gx;
                y_next = gy;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

### sv/cordic_vector_rotator_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// cordic_vector_rotator_unit
// Rotates the configured start vector by a streamed angle (CORDIC, 8 steps).
// ============================================================================
// Usage:
//   s_tdata[9:0] carries an unsigned angle in radians with 7 fraction bits.
//   m_tdata returns the rotated vector: out_x in [7:0], out_y in [15:8],
//   each the low 8 bits of a two's complement value.
//   The cfg channel writes start_x (index 0) or start_y (index 1) from
//   cfg_data; other indexes are dropped. cfg_ready is always high. Write
//   only while no angle is in flight.
// Pipeline: ITERATIONS + 2 register stages (one quadrant-fold stage, one per
//   micro-rotation, one gain/output stage).
// Throughput: one angle per cycle while m_tready is high; every stage is
//   registered, has its own valid bit and takes new data when empty or draining.
// Reset (aresetn low, synchronous): all stages empty, start_x = 127,
//   start_y = 0.
// Stall: with m_tready low the result is held in the output register;
//   earlier stages keep filling bubbles, and s_tready drops only once
//   every stage holds an item. Nothing is lost or repeated.
// ============================================================================
module cordic_vector_rotator_unit #(
    parameter int ITERATIONS = cvr_pkg::ITERATIONS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [9:0] angle, [15:10] zero
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [7:0] out_x, [15:8] out_y
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cvr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cvr_pkg::COORD_W-1:0]       cfg_data
);

    logic signed [cvr_pkg::COORD_W-1:0]   start_x_reg;
    logic signed [cvr_pkg::COORD_W-1:0]   start_y_reg;
    logic signed [cvr_pkg::COORD_W-1:0]   out_x;
    logic signed [cvr_pkg::COORD_W-1:0]   out_y;

    cvr_pkg::stage_t                      stg_data  [0:ITERATIONS];
    logic                                 stg_valid [0:ITERATIONS];
    logic                                 stg_ready [0:ITERATIONS];

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg <= 8'sd127;
            start_y_reg <= 8'sd0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == cvr_pkg::REG_START_X) begin
                start_x_reg <= cfg_data;
            end
            if (cfg_index == cvr_pkg::REG_START_Y) begin
                start_y_reg <= cfg_data;
            end
        end
    end

    // Quadrant fold
    cvr_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .angle     (s_tdata[cvr_pkg::ANGLE_W-1:0]),
        .start_x   (start_x_reg),
        .start_y   (start_y_reg),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    // Micro-rotation chain
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
        cvr_micro_rot #(
            .STAGE (i)
        ) u_rot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    // Gain correction and output register
    cvr_gain_quad u_gain_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[ITERATIONS]),
        .in_ready  (stg_ready[ITERATIONS]),
        .in_data   (stg_data[ITERATIONS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y)
    );

    assign m_tdata = {out_y, out_x};

endmodule

### verif/cordic_vector_rotator_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// cordic_vector_rotator_unit_tb
// Self-checking bench for the streamed CORDIC vector rotator.
// ============================================================================
// A short table of directed angles and register writes runs first. Rows at
// multiples of pi/2 under the reset vector carry their result typed in; all
// other rows are checked against a local fixed-point model of the rotator.
// Then about 600 random angles follow, in phases that each set a new start
// vector, extremes included. The sender works in random bursts, the receiver
// stalls on its own pattern, and once it holds off long enough to back the
// pipeline up into the input.
// ============================================================================
module cordic_vector_rotator_unit_tb;

    localparam int COORD_W      = cvr_pkg::COORD_W;
    localparam int ANGLE_W      = cvr_pkg::ANGLE_W;
    localparam int CFG_IDX_W    = cvr_pkg::CFG_IDX_W;
    localparam int QUAD_W       = cvr_pkg::QUAD_W;
    localparam int PIPE_LAT     = cvr_pkg::ITERATIONS + 2;
    localparam int PHASES       = 7;
    localparam int PHASE_ANGLES = 86;
    localparam int HOLD_CYCLES  = 64;
    localparam int HOLD_AT      = 150;

    // One result transfer: out_x in the low byte, out_y in the high byte
    typedef struct packed {
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_x;
    } vec_result_t;

    typedef enum logic {ROW_ANGLE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [ANGLE_W-1:0]   angle;
        bit                   given;
        vec_result_t          result;
        logic [CFG_IDX_W-1:0] idx;
        logic [COORD_W-1:0]   data;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;    // [9:0] angle, [15:10] zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;    // [7:0] out_x, [15:8] out_y
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    // Start vector as the bench believes it to be
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;

    vec_result_t vec_expect_q[$];
    dir_row_t    dir_tab[$];

    int n_angles_sent;
    int n_directed;
    int n_results_ok;
    int n_cfg_writes;
    int n_in_stall;
    int n_fail;
    int burst_left;

    cordic_vector_rotator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop
    initial begin
        #2000000;
        $display("FAIL cordic_vector_rotator_unit");
        $finish;
    end

    // 16-bit two's complement wrap
    function automatic int wrap16(input int v);
        shortint t;
        t = shortint'(v);
        return int'(t);
    endfunction

    // Fixed-point rotation of (sx, sy) by angle, as the datapath computes it
    function automatic vec_result_t rotate_start_vector(
        input logic [ANGLE_W-1:0]        angle,
        input logic signed [COORD_W-1:0] sx,
        input logic signed [COORD_W-1:0] sy
    );
        int                a;
        int                x;
        int                y;
        int                dx;
        int                dy;
        int                rx;
        int                ry;
        logic [QUAD_W-1:0] quad;
        vec_result_t       r;
        a    = int'(angle);
        quad = QUAD_W'(a / cvr_pkg::HALF_PI_FX);
        a    = a % cvr_pkg::HALF_PI_FX;
        x    = wrap16(int'(sx) * (1 << cvr_pkg::FRAC_BITS));
        y    = wrap16(int'(sy) * (1 << cvr_pkg::FRAC_BITS));
        // micro-rotations, steered by the sign of the residual angle
        for (int i = 0; i < cvr_pkg::ITERATIONS; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (a >= 0) begin
                x = wrap16(x - dy);
                y = wrap16(y + dx);
                a = a - int'(cvr_pkg::atan_val(i));
            end else begin
                x = wrap16(x + dy);
                y = wrap16(y - dx);
                a = a + int'(cvr_pkg::atan_val(i));
            end
        end
        // gain 0x4D/128 as 1/128 + 1/32 + 1/16 + 1/2
        x = wrap16(((x >>> 7) + (x >>> 5) + (x >>> 4) + (x >>> 1)) >>> 7);
        y = wrap16(((y >>> 7) + (y >>> 5) + (y >>> 4) + (y >>> 1)) >>> 7);
        // back into the original quadrant
        case (quad)
            cvr_pkg::QUAD_0: begin rx = x;  ry = y;  end
            cvr_pkg::QUAD_1: begin rx = -y; ry = x;  end
            cvr_pkg::QUAD_2: begin rx = -x; ry = -y; end
            default:         begin rx = y;  ry = -x; end
        endcase
        r.out_x = rx[7:0];
        r.out_y = ry[7:0];
        return r;
    endfunction

    function automatic dir_row_t row_angle(input logic [ANGLE_W-1:0] angle);
        dir_row_t r;
        r = '{kind: ROW_ANGLE, angle: angle, given: 1'b0, result: '0, idx: '0, data: '0};
        return r;
    endfunction

    function automatic dir_row_t row_known(input logic [ANGLE_W-1:0] angle,
                                           input logic [COORD_W-1:0] ex,
                                           input logic [COORD_W-1:0] ey);
        dir_row_t r;
        r = row_angle(angle);
        r.given  = 1'b1;
        r.result = '{out_y: ey, out_x: ex};
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [COORD_W-1:0] data);
        dir_row_t r;
        r = '{kind: ROW_CFG, angle: '0, given: 1'b0, result: '0, idx: idx, data: data};
        return r;
    endfunction

    // Random angle, biased now and then toward the quadrant boundaries
    function automatic logic [ANGLE_W-1:0] pick_angle();
        int k;
        if ($urandom_range(0, 4) == 0) begin
            k = int'($urandom_range(0, 5)) * cvr_pkg::HALF_PI_FX
                + int'($urandom_range(0, 2)) - 1;
            if (k < 0)
                k = 0;
        end else begin
            k = int'($urandom_range(0, 1023));
        end
        return ANGLE_W'(k);
    endfunction

    // Offer one angle, honoring the burst/gap pattern; record the expectation
    task automatic feed_angle(input logic [ANGLE_W-1:0] angle, input bit given,
                              input vec_result_t known);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? int'($urandom_range(40, 80))
                                                     : int'($urandom_range(1, 20));
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, angle};
        do @(posedge aclk); while (!s_tready);
        if (given)
            vec_expect_q.push_back(known);
        else
            vec_expect_q.push_back(rotate_start_vector(angle, cur_x, cur_y));
        n_angles_sent++;
        burst_left--;
    endtask

    // Stop offering and let every angle in flight come out
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (vec_expect_q.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 2) @(posedge aclk);
    endtask

    // One register write; unknown indexes leave the start vector alone
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == cvr_pkg::REG_START_X)
            cur_x = data;
        else if (idx == cvr_pkg::REG_START_Y)
            cur_y = data;
        n_cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: changing stall pattern, plus one long hold-off
    initial begin
        rx_mode_t mode;
        int       left;
        bit       held;
        m_tready = 1'b0;
        mode     = RX_OPEN;
        left     = 0;
        held     = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && n_angles_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                left = int'($urandom_range(40, 200));
            end
            left--;
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    // Count cycles where the input is offered but held off
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready)
            n_in_stall++;
    end

    // Result checker: compare each transfer with the oldest expectation
    always @(posedge aclk) begin
        vec_result_t got;
        vec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (vec_expect_q.size() == 0) begin
                $error("unexpected result: out_x %0d out_y %0d",
                       $signed(got.out_x), $signed(got.out_y));
                n_fail++;
            end else begin
                want = vec_expect_q.pop_front();
                if (got.out_x !== want.out_x) begin
                    $error("out_x mismatch: expected %0d, got %0d",
                           $signed(want.out_x), $signed(got.out_x));
                    n_fail++;
                end
                if (got.out_y !== want.out_y) begin
                    $error("out_y mismatch: expected %0d, got %0d",
                           $signed(want.out_y), $signed(got.out_y));
                    n_fail++;
                end
                n_results_ok++;
            end
        end
    end

    // Stimulus
    initial begin
        logic signed [COORD_W-1:0] ph_x[5];
        logic signed [COORD_W-1:0] ph_y[5];
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cur_x         = 8'sd127;
        cur_y         = 8'sd0;
        n_angles_sent = 0;
        n_directed    = 0;
        n_results_ok  = 0;
        n_cfg_writes  = 0;
        n_in_stall    = 0;
        n_fail        = 0;
        burst_left    = 0;
        ph_x = '{8'sh7F, 8'sh80, 8'sh7F, 8'sh80, 8'sh00};
        ph_y = '{8'sh00, 8'sh80, 8'sh7F, 8'sh7F, 8'sh80};

        // Reset vector (127, 0): multiples of pi/2 land on the axes at 125
        dir_tab.push_back(row_known(10'd0,    8'd125, 8'd0));
        dir_tab.push_back(row_known(10'd201,  8'd0,   8'd125));
        dir_tab.push_back(row_known(10'd402,  8'h83,  8'd0));
        dir_tab.push_back(row_known(10'd603,  8'd0,   8'h83));
        // full turn wraps the quadrant count
        dir_tab.push_back(row_known(10'd804,  8'd125, 8'd0));
        dir_tab.push_back(row_angle(10'd1023));
        dir_tab.push_back(row_angle(10'd200));
        dir_tab.push_back(row_angle(10'd1));
        dir_tab.push_back(row_angle(10'd100));
        dir_tab.push_back(row_angle(10'h155));
        dir_tab.push_back(row_angle(10'h2AA));
        // most negative x, largest y; writes to unknown indexes are dropped
        dir_tab.push_back(row_cfg(cvr_pkg::REG_START_X, 8'h80));
        dir_tab.push_back(row_cfg(cvr_pkg::REG_START_Y, 8'h7F));
        dir_tab.push_back(row_cfg(CFG_IDX_W'(2), 8'h00));
        dir_tab.push_back(row_cfg(CFG_IDX_W'(255), 8'h55));
        dir_tab.push_back(row_angle(10'd0));
        dir_tab.push_back(row_angle(10'd150));
        dir_tab.push_back(row_angle(10'd500));
        dir_tab.push_back(row_angle(10'd1005));
        // (127, 127) overflows the 16-bit micro-rotations and the 8-bit output
        dir_tab.push_back(row_cfg(cvr_pkg::REG_START_X, 8'h7F));
        dir_tab.push_back(row_cfg(cvr_pkg::REG_START_Y, 8'h7F));
        dir_tab.push_back(row_angle(10'd50));
        dir_tab.push_back(row_angle(10'd300));
        dir_tab.push_back(row_angle(10'd700));
        dir_tab.push_back(row_angle(10'd1023));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                drain();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                feed_angle(dir_tab[i].angle, dir_tab[i].given, dir_tab[i].result);
                n_directed++;
            end
        end
        drain();

        // Random phases, each with its own start vector
        for (int p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                px = ph_x[p];
                py = ph_y[p];
            end else begin
                px = COORD_W'($urandom);
                py = COORD_W'($urandom);
            end
            write_reg(cvr_pkg::REG_START_X, px);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), COORD_W'($urandom));
            write_reg(cvr_pkg::REG_START_Y, py);
            for (int n = 0; n < PHASE_ANGLES; n++)
                feed_angle(pick_angle(), 1'b0, '0);
            drain();
        end

        $display("Run covered %0d angles (%0d directed) over %0d register writes;",
                 n_angles_sent, n_directed, n_cfg_writes);
        $display("%0d results checked, input held off %0d cycles by back-pressure.",
                 n_results_ok, n_in_stall);
        if (n_fail == 0)
            $display("PASS cordic_vector_rotator_unit");
        else
            $display("FAIL cordic_vector_rotator_unit");
        $finish;
    end

endmodule
